@@ src/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;

  // Command codes carried on the request channel
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of a chain
  typedef enum logic [2:0] {
    CELL_HOLD,    // keep contents
    CELL_INSERT,  // shift away from the head, new value enters at the head
    CELL_REMOVE,  // shift towards the head, head entry leaves
    CELL_APPEND,  // first free cell takes the new value
    CELL_DROP     // last held cell lets go of its entry
  } cell_op_t;

endpackage

@@ src/deq_cell.sv @@
// One storage cell of a chain: an entry, its valid flag and the neighbour moves.
module deq_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::cell_op_t                   op,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  input  logic signed [deq_pkg::DATA_W-1:0]   left_data,
  input  logic                                left_valid,
  input  logic signed [deq_pkg::DATA_W-1:0]   right_data,
  input  logic                                right_valid,
  output logic signed [deq_pkg::DATA_W-1:0]   data,
  output logic                                valid
);

  logic signed [deq_pkg::DATA_W-1:0] data_next;
  logic                              valid_next;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    unique case (op)
      deq_pkg::CELL_HOLD: begin
      end
      deq_pkg::CELL_INSERT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      deq_pkg::CELL_REMOVE: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      deq_pkg::CELL_APPEND: begin
        if (!valid && left_valid) begin
          data_next  = value;
          valid_next = 1'b1;
        end
      end
      deq_pkg::CELL_DROP: begin
        if (valid && !right_valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

@@ src/deq_chain.sv @@
// A row of cells held packed against the head, exposing the head entry.
module deq_chain #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::cell_op_t                   op,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  output logic signed [deq_pkg::DATA_W-1:0]   head_data,
  output logic                                head_valid
);

  logic signed [deq_pkg::DATA_W-1:0] cell_data  [DEPTH];
  logic                              cell_valid [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::DATA_W-1:0] l_data;
    logic                              l_valid;
    logic signed [deq_pkg::DATA_W-1:0] r_data;
    logic                              r_valid;

    // The head cell sees the incoming value as its left neighbour
    if (i == 0) begin : g_head
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    // The tail cell sees an empty right neighbour
    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .value       (value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  assign head_data  = cell_data[0];
  assign head_valid = cell_valid[0];

endmodule

@@ src/double_ended_queue.sv @@
// An accepted request's result appears in the output register in the next cycle.
// Throughput: one request per cycle while no result is stalled; every cell updates in the same edge as the request.
// A result held under res_stall stalls new requests until it is taken.
// Reset clears the occupancy, the result valid and every cell's valid flag at once;
// stored entries are not cleared and are never read before being written.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          status,
  output logic [OCC_W-1:0]                    occupancy,
  output logic signed [deq_pkg::DATA_W-1:0]   front_value,
  output logic signed [deq_pkg::DATA_W-1:0]   back_value
);

  // The queue is kept twice: the front chain holds the entries front first,
  // the back chain holds the same entries back first. Each end of the queue
  // is therefore always the head cell of one chain, and every update is a
  // neighbour-to-neighbour move inside the cells.

  logic                              accept;
  logic                              is_push;
  logic                              full;
  logic                              empty;
  logic                              refused;
  logic [OCC_W-1:0]                  count;
  logic [OCC_W-1:0]                  count_next;
  logic [1:0]                        status_next;
  deq_pkg::cell_op_t                 front_op;
  deq_pkg::cell_op_t                 back_op;
  logic signed [deq_pkg::DATA_W-1:0] front_head;
  logic                              front_head_valid;
  logic signed [deq_pkg::DATA_W-1:0] back_head;
  logic                              back_head_valid;

  // Hold requests while a finished result waits to be taken
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_push = (cmd == deq_pkg::CMD_PUSH_FRONT) || (cmd == deq_pkg::CMD_PUSH_BACK);
  assign full    = (count == OCC_W'(DEPTH));
  assign empty   = (count == '0);
  assign refused = is_push ? full : empty;

  // Decode the request into one operation for each chain; a refused request
  // leaves both chains and the count untouched.
  always_comb begin
    front_op    = deq_pkg::CELL_HOLD;
    back_op     = deq_pkg::CELL_HOLD;
    count_next  = count;
    status_next = deq_pkg::ST_OK;
    if (refused) begin
      status_next = is_push ? deq_pkg::ST_FULL : deq_pkg::ST_EMPTY;
    end else begin
      unique case (cmd)
        deq_pkg::CMD_PUSH_FRONT: begin
          front_op   = deq_pkg::CELL_INSERT;
          back_op    = deq_pkg::CELL_APPEND;
          count_next = count + OCC_W'(1);
        end
        deq_pkg::CMD_PUSH_BACK: begin
          front_op   = deq_pkg::CELL_APPEND;
          back_op    = deq_pkg::CELL_INSERT;
          count_next = count + OCC_W'(1);
        end
        deq_pkg::CMD_POP_FRONT: begin
          front_op   = deq_pkg::CELL_REMOVE;
          back_op    = deq_pkg::CELL_DROP;
          count_next = count - OCC_W'(1);
        end
        deq_pkg::CMD_POP_BACK: begin
          front_op   = deq_pkg::CELL_DROP;
          back_op    = deq_pkg::CELL_REMOVE;
          count_next = count - OCC_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Only an accepted request may move the chains
  deq_chain #(.DEPTH(DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .op         (accept ? front_op : deq_pkg::CELL_HOLD),
    .value      (value),
    .head_data  (front_head),
    .head_valid (front_head_valid)
  );

  deq_chain #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .op         (accept ? back_op : deq_pkg::CELL_HOLD),
    .value      (value),
    .head_data  (back_head),
    .head_valid (back_head_valid)
  );

  // Count and result register; the state only moves on an accepted request,
  // which cannot happen while a result is stalled, so the payload holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
      status    <= deq_pkg::ST_OK;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign occupancy   = count;
  // Drop stale cell contents to zero when the queue is empty
  assign front_value = front_head_valid ? front_head : '0;
  assign back_value  = back_head_valid ? back_head : '0;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_front_matches_count : assert property (@(posedge clk) disable iff (rst)
    front_head_valid == (count != '0))
    else $error("front chain head disagrees with occupancy");

  a_back_matches_count : assert property (@(posedge clk) disable iff (rst)
    back_head_valid == (count != '0))
    else $error("back chain head disagrees with occupancy");

  a_refused_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (accept && refused) |=> (count == $past(count)) && (status != deq_pkg::ST_OK))
    else $error("refused request changed the queue");

  a_accept_gives_result : assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted request produced no result");

endmodule

@@ bench/double_ended_queue_test.sv @@
// Self-checking bench for the double-ended queue: command streams checked against a predictor.
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS           = deq_pkg::DEPTH_DEFAULT;
  localparam int OCC_BITS        = $clog2(SLOTS + 1);
  localparam int RANDOM_REQUESTS = 1100;
  localparam int MAX_WAIT        = 17;
  // Worst honest lull: a full sender gap plus a full receiver stall plus the pipeline.
  // Take it many times over so that only a real hang trips the watchdog.
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 4;

  typedef struct packed {
    logic [1:0]                        status;
    logic [OCC_BITS-1:0]               occupancy;
    logic signed [deq_pkg::DATA_W-1:0] front_value;
    logic signed [deq_pkg::DATA_W-1:0] back_value;
  } deque_result_t;

  // Mirror of the ring contents plus the list of results still owed by the block.
  class deque_scoreboard;
    logic signed [deq_pkg::DATA_W-1:0] slot_data[SLOTS];
    int                                head;
    int                                held;
    deque_result_t                     awaited[$];
    int                                mismatches;

    function new();
      head       = 0;
      held       = 0;
      mismatches = 0;
      foreach (slot_data[i]) slot_data[i] = '0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it must produce.
    function void note_request(logic [1:0] op, logic signed [deq_pkg::DATA_W-1:0] data);
      deque_result_t r;
      r.status = deq_pkg::ST_OK;
      unique case (op)
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
          if (held >= SLOTS) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            if (op == deq_pkg::CMD_PUSH_FRONT) begin
              head = (head + SLOTS - 1) % SLOTS;
              slot_data[head] = data;
            end else begin
              slot_data[(head + held) % SLOTS] = data;
            end
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            if (op == deq_pkg::CMD_POP_FRONT) head = (head + 1) % SLOTS;
            held--;
          end
        end
      endcase
      r.occupancy = OCC_BITS'(held);
      if (held == 0) begin
        r.front_value = '0;
        r.back_value  = '0;
      end else begin
        r.front_value = slot_data[head];
        r.back_value  = slot_data[(head + held - 1) % SLOTS];
      end
      awaited.push_back(r);
    endfunction

    task report_mismatch(string line);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, line);
    endtask

    task check_result(logic [1:0] st, logic [OCC_BITS-1:0] occ,
                      logic signed [deq_pkg::DATA_W-1:0] front,
                      logic signed [deq_pkg::DATA_W-1:0] back);
      deque_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding (status %0d occ %0d)",
                                  st, occ));
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      if (occ !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", occ, want.occupancy));
      if (front !== want.front_value)
        report_mismatch($sformatf("front_value %0d, expected %0d", front, want.front_value));
      if (back !== want.back_value)
        report_mismatch($sformatf("back_value %0d, expected %0d", back, want.back_value));
    endtask
  endclass

  logic                              clk;
  logic                              rst       = 1'b1;
  logic                              cmd_valid = 1'b0;
  logic                              cmd_stall;
  logic [1:0]                        cmd       = deq_pkg::CMD_PUSH_FRONT;
  logic signed [deq_pkg::DATA_W-1:0] value     = '0;
  logic                              res_valid;
  logic                              res_stall = 1'b0;
  logic [1:0]                        status;
  logic [OCC_BITS-1:0]               occupancy;
  logic signed [deq_pkg::DATA_W-1:0] front_value;
  logic signed [deq_pkg::DATA_W-1:0] back_value;

  deque_scoreboard board = new();
  // While set, both sides run flat out with no idle cycles at all.
  bit steady = 1'b0;
  int quiet_cycles = 0;

  double_ended_queue dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .occupancy   (occupancy),
    .front_value (front_value),
    .back_value  (back_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length for one request or one result: mostly short, now and then the full range.
  function automatic int draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_WAIT);
    return $urandom_range(0, 2);
  endfunction

  // Payload mix: the two extremes, small magnitudes of either sign, and full random words.
  function automatic logic signed [deq_pkg::DATA_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 15);
      3: return -(32'sd1 + $urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Present one request, hold it until the block takes it, then record it.
  // Valid is left high on return so that a zero-gap follower goes back to back.
  task automatic send_request(input logic [1:0] op,
                              input logic signed [deq_pkg::DATA_W-1:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= op;
    value     <= data;
    do @(posedge clk); while (cmd_stall);
    board.note_request(op, data);
  endtask

  // Result side: stall for a drawn number of cycles, then release until one result is taken.
  initial begin : result_sink
    int hold;
    @(negedge rst);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      board.check_result(status, occupancy, front_value, back_value);
  end

  // Watchdog: abandon the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("double_ended_queue_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         push_pct;
    logic [1:0] op;
    push_pct = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: refused pops on the empty queue, with junk in the value field.
    send_request(deq_pkg::CMD_POP_FRONT, 32'sh12345678);
    send_request(deq_pkg::CMD_POP_BACK, -32'sd1);
    // Front push into an empty queue: the lone entry is both ends; a back pop empties it.
    send_request(deq_pkg::CMD_PUSH_FRONT, 32'sh7fffffff);
    send_request(deq_pkg::CMD_POP_BACK, 32'sd0);
    // Same from the other side: back push, then a front pop that empties the queue.
    send_request(deq_pkg::CMD_PUSH_BACK, 32'sh80000000);
    send_request(deq_pkg::CMD_POP_FRONT, 32'sd0);
    send_request(deq_pkg::CMD_PUSH_FRONT, -32'sd1);
    send_request(deq_pkg::CMD_PUSH_BACK, 32'sd0);
    // Fill to the brim from both ends so the head wraps below slot zero.
    for (int i = 0; i < SLOTS - 2; i++)
      send_request((i % 2) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
                   ((i % 2) ? 32'sh55555555 : 32'shaaaaaaaa) + i);
    // Full queue: both pushes must be refused and leave the contents alone.
    send_request(deq_pkg::CMD_PUSH_FRONT, 32'sd1);
    send_request(deq_pkg::CMD_PUSH_BACK, 32'sd2);

    // Random part: phases of 64 requests, each with its own push bias, so the queue
    // drifts up to full, down to empty, or wanders around the middle and wraps.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) begin
        steady = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 80;
          default: push_pct = 97;
        endcase
      end
      if ($urandom_range(1, 100) <= push_pct)
        op = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
      send_request(op, draw_value());
    end
    cmd_valid <= 1'b0;
    steady = 1'b0;

    // Drain: wait for every owed result, then let a few more cycles pass to catch strays.
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (board.mismatches == 0) begin
      $display("double_ended_queue_test: PASS");
    end else begin
      $display("double_ended_queue_test: FAIL");
    end
    $finish;
  end

endmodule
